FILE: rtl/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, ignored while reset is asserted
`define LWM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("like_wildcard_matcher: assertion failed");

// Concurrent assertion, also checked across reset
`define LWM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("like_wildcard_matcher: assertion failed");

`endif

FILE: rtl/lwm_pkg.sv
// Constants and types for the LIKE wildcard matcher
`default_nettype none

package lwm_pkg;

    localparam int unsigned HELD_BYTES = 16;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 64;
    localparam int unsigned LEN_W      = 5;

    localparam logic [7:0] PCT  = 8'h25;
    localparam logic [7:0] ANY1 = 8'h5F;

    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/like_wildcard_matcher.sv
// LIKE wildcard matcher: top level with config registers and position-set update
//
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+------------------------------
//  input    | s_valid s_ready s_ch s_has_char s_last  | one string byte or empty mark
//  result   | m_valid m_ready m_matched               | one match bit per string
//  config   | psel penable pwrite paddr pwdata ...    | one 64-bit register write
//
// One beat per cycle unless a stalled result holds it back: an input register, the
// position-set update, a result register. A beat without last gives no result.
// Reset clears the valid flags, the pattern registers and the position set, and sets the start flag.
// A stalled result holds back the input register only when a further beat needs the
// result register; otherwise input keeps flowing.
`default_nettype none

module like_wildcard_matcher #(
    parameter int PATTERN_MAX = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [7:0]                       s_ch,
    input  wire                              s_has_char,
    input  wire                              s_last,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_matched,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [lwm_pkg::ADDR_W-1:0]       paddr,
    input  wire  [lwm_pkg::DATA_W-1:0]       pwdata,
    output logic [lwm_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    localparam int EFF   = (PATTERN_MAX < int'(lwm_pkg::HELD_BYTES)) ?
                           PATTERN_MAX : int'(lwm_pkg::HELD_BYTES);
    localparam int POS_W = EFF + 1;

    // configuration
    logic [63:0]               pat_low_reg;
    logic [63:0]               pat_high_reg;
    logic [lwm_pkg::LEN_W-1:0] pat_len_reg;
    logic                      cfg_wr;
    lwm_pkg::reg_idx_t         cfg_idx;

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_ch_reg;
    logic       in_has_char_reg;
    logic       in_last_reg;

    // matcher state
    logic [POS_W-1:0] active_reg, active_next;
    logic             start_reg;

    // result register
    logic out_vld_reg, out_vld_next;
    logic out_matched_reg;

    logic                      proceed;
    logic                      matched_now;
    logic [127:0]              pat_all;
    logic [lwm_pkg::LEN_W-1:0] n_used;
    logic [EFF-1:0]            pct_mask;
    logic [EFF-1:0]            step_mask;
    logic [EFF-1:0]            eq_mask;
    logic [POS_W-1:0]          keep;
    logic [POS_W-1:0]          cur_set;
    logic [POS_W-1:0]          stepped;
    logic [POS_W-1:0]          one_set;

    function automatic logic [POS_W-1:0] close_set(input logic [POS_W-1:0] v,
                                                   input logic [EFF-1:0]   pm);
        logic [POS_W-1:0] r;
        logic             run;
        logic             acc;
        for (int k = 0; k < POS_W; k++) begin
            run = 1'b1;
            acc = v[k];
            for (int q = k - 1; q >= 0; q--) begin
                run = run & pm[q];
                acc = acc | (v[q] & run);
            end
            r[k] = acc;
        end
        return r;
    endfunction

    // APB port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = lwm_pkg::reg_idx_t'(paddr[4:3]);

    always_comb begin
        case (cfg_idx)
            lwm_pkg::REG_PAT_LOW:  prdata = pat_low_reg;
            lwm_pkg::REG_PAT_HIGH: prdata = pat_high_reg;
            lwm_pkg::REG_PAT_LEN:  prdata = {{(lwm_pkg::DATA_W-lwm_pkg::LEN_W){1'b0}},
                                             pat_len_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                lwm_pkg::REG_PAT_LOW:  pat_low_reg  <= pwdata;
                lwm_pkg::REG_PAT_HIGH: pat_high_reg <= pwdata;
                lwm_pkg::REG_PAT_LEN:  pat_len_reg  <= pwdata[lwm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign proceed     = in_vld_reg && (!in_last_reg || !out_vld_reg || m_ready);
    assign s_ready     = !in_vld_reg || proceed;
    assign in_vld_next = s_ready ? s_valid : in_vld_reg;
    assign m_valid     = out_vld_reg;
    assign m_matched   = out_matched_reg;

    // pattern decode
    assign pat_all = {pat_high_reg, pat_low_reg};
    assign n_used  = (pat_len_reg > lwm_pkg::LEN_W'(EFF)) ? lwm_pkg::LEN_W'(EFF) : pat_len_reg;
    assign one_set = POS_W'(1);

    always_comb begin
        for (int p = 0; p < EFF; p++) begin
            pct_mask[p]  = (pat_all[8*p +: 8] == lwm_pkg::PCT)
                           && (lwm_pkg::LEN_W'(p) < n_used);
            eq_mask[p]   = (pat_all[8*p +: 8] == lwm_pkg::ANY1)
                           || (pat_all[8*p +: 8] == in_ch_reg);
            step_mask[p] = (lwm_pkg::LEN_W'(p) < n_used);
        end
        for (int k = 0; k < POS_W; k++) begin
            keep[k] = (lwm_pkg::LEN_W'(k) <= n_used);
        end
    end

    // position-set update
    always_comb begin
        if (start_reg) begin
            cur_set = close_set(one_set, pct_mask);
        end else begin
            cur_set = active_reg & keep;
        end
        stepped = '0;
        for (int p = 0; p < EFF; p++) begin
            if (cur_set[p] && step_mask[p]) begin
                if (pct_mask[p]) begin
                    stepped[p] = 1'b1;
                end else if (eq_mask[p]) begin
                    stepped[p+1] = 1'b1;
                end
            end
        end
        if (in_has_char_reg) begin
            active_next = close_set(stepped, pct_mask) & keep;
        end else begin
            active_next = cur_set & keep;
        end
        matched_now = active_next[n_used[$clog2(POS_W)-1:0]];
    end

    always_comb begin
        out_vld_next = out_vld_reg && !m_ready;
        if (proceed && in_last_reg) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            active_reg  <= '0;
            start_reg   <= 1'b1;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (proceed) begin
                active_reg <= active_next;
                start_reg  <= in_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg       <= s_ch;
            in_has_char_reg <= s_has_char;
            in_last_reg     <= s_last;
        end
        if (proceed && in_last_reg) begin
            out_matched_reg <= matched_now;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lwm_checker.sv
// Port-level assertions for the LIKE wildcard matcher, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module lwm_checker (
    input wire aclk,
    input wire aresetn,
    input wire s_ready,
    input wire m_valid,
    input wire m_ready,
    input wire m_matched,
    input wire pready
);

    // after reset the result side is empty and the input side open
    `LWM_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!m_valid && s_ready))

    // input only stalls behind a result that is itself stalled
    `LWM_ASSERT(a_stall_cause, aclk, aresetn, !s_ready |-> (m_valid && !m_ready))

    // a stalled result beat holds
    `LWM_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_matched)))

    // register port never inserts wait states
    `LWM_ASSERT(a_pready, aclk, aresetn, pready)

endmodule

bind like_wildcard_matcher lwm_checker u_lwm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_matched (m_matched),
    .pready    (pready)
);

`default_nettype wire
